FILE: rtl/lsr15_pkg.sv
// Package for the 15-bit-halves LCG seed recovery block.
// Holds the generator constants and the sizes of the divider pipeline.
// Depends on nothing.
package lsr15_pkg;

   localparam logic [17:0] LcgMult     = 18'h343FD;
   localparam logic [31:0] LcgSub      = 32'h0025_9EC4;
   // Offsets above this value leave room for only six candidates.
   localparam logic [30:0] SixLaneMax  = 31'h43FA_BC02;
   localparam logic [17:0] LowLimit    = 18'h10000;
   localparam int          NumLanes    = 7;
   localparam int          DivSteps    = 17;
   localparam int          StepsPerStg = 3;
   localparam int          DivStages   = (DivSteps + StepsPerStg - 1) / StepsPerStg;
   localparam int          NumStages   = DivStages + 1;

   typedef logic [NumLanes-1:0] lane_mask_type;

endpackage

FILE: rtl/lcg_seed_recovery_15bit_halves.sv
// Top level of the LCG seed recovery block: front-end offset computation,
// a pipelined restoring divider over seven candidate lanes and a result serializer.
// Depends on lsr15_pkg.
//
// Usage:
// The req_ channel takes one beat holding six 5-bit values. Three of them form
// bits 16..30 of a first generator state, the other three those of the next
// state. The rsp_ channel returns every 32-bit first state consistent with both,
// one beat per candidate, each solution followed by the same word with bit 31
// flipped. rsp_last marks the final beat of an item. When no state fits, a
// single beat with rsp_found low, rsp_recovered_seed zero and rsp_last high is
// returned.
// A request may enter every cycle while req_stall is low; the seven lanes are
// divided by the constant multiplier in a six-stage restoring divider, up to
// three quotient bits per stage. The serializer sets the sustained rate: an item
// takes one beat when nothing matches and two beats per solution otherwise.
// Reset empties the pipeline and the serializer. When the receiver stalls, the
// current response beat holds, and the whole pipeline stalls behind its waiting
// final stage and then stalls the request channel; no beat is lost or repeated.
module lcg_seed_recovery_15bit_halves
   import lsr15_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_health_iv,
   input  logic [4:0]  req_attack_iv,
   input  logic [4:0]  req_defense_iv,
   input  logic [4:0]  req_special_attack_iv,
   input  logic [4:0]  req_special_defense_iv,
   input  logic [4:0]  req_speed_iv,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_recovered_seed,
   output logic        rsp_found,
   output logic        rsp_last
);

   localparam int Last = NumStages - 1;

   // Pipeline registers. Stage 0 holds the offset t; stages 1.. hold the
   // partial remainders and quotients of every lane.
   logic        vld_ff   [NumStages];
   logic        vld_in   [NumStages];
   logic [30:0] t_ff     [NumStages];
   logic [30:0] t_in     [NumStages];
   logic [14:0] first_ff [NumStages];
   logic [14:0] first_in [NumStages];
   logic        six_ff   [NumStages];
   logic        six_in   [NumStages];
   logic [17:0] rem_ff   [1:Last][NumLanes];
   logic [17:0] rem_in   [1:Last][NumLanes];
   logic [16:0] quo_ff   [1:Last][NumLanes];
   logic [16:0] quo_in   [1:Last][NumLanes];

   // Serializer registers.
   logic          ser_vld_ff, ser_vld_in;
   lane_mask_type mask_ff, mask_in;
   logic [15:0]   low_ff [NumLanes];
   logic [15:0]   low_in [NumLanes];
   logic [14:0]   sfirst_ff, sfirst_in;
   logic          half_ff, half_in;
   logic          found_ff, found_in;

   logic          advance;
   logic          ser_load;
   logic          rsp_accept;
   lane_mask_type match;
   lane_mask_type lane_sel;
   logic [15:0]   sel_low;

   logic [14:0] f15, s15;
   logic [15:0] prod;
   logic [30:0] diff;

   assign rsp_accept = rsp_valid && !rsp_stall;
   assign ser_load   = vld_ff[Last] && (!ser_vld_ff || (rsp_accept && rsp_last));
   assign advance    = !vld_ff[Last] || ser_load;
   assign req_stall  = !advance;

   // Front end: the second state's upper half minus the contribution of the
   // first state's known bits gives the offset t in its low 31 bits.
   always_comb begin
      f15  = {req_defense_iv, req_attack_iv, req_health_iv};
      s15  = {req_special_defense_iv, req_special_attack_iv, req_speed_iv};
      prod = 16'(32'(LcgMult) * 32'(f15));
      diff = 31'({s15, 16'h0000} - {prod, 16'h0000} - LcgSub);
   end

   // Divider stages: restoring division of {k, t} by the multiplier.
   always_comb begin
      logic [17:0] rr;
      logic [16:0] qq;
      logic [18:0] w;
      int          idx;
      vld_in[0]   = req_valid;
      t_in[0]     = diff;
      first_in[0] = f15;
      six_in[0]   = (diff <= SixLaneMax);
      for (int s = 1; s < NumStages; s++) begin
         vld_in[s]   = vld_ff[s-1];
         t_in[s]     = t_ff[s-1];
         first_in[s] = first_ff[s-1];
         six_in[s]   = six_ff[s-1];
         for (int l = 0; l < NumLanes; l++) begin
            if (s == 1) begin
               rr = {1'b0, 3'(l), t_ff[0][30:17]};
               qq = '0;
            end else begin
               rr = rem_ff[s-1][l];
               qq = quo_ff[s-1][l];
            end
            for (int j = 0; j < StepsPerStg; j++) begin
               idx = (s - 1) * StepsPerStg + j;
               if (idx < DivSteps) begin
                  w = {rr, t_ff[s-1][DivSteps-1-idx]};
                  if (w >= 19'(LcgMult)) begin
                     w  = w - 19'(LcgMult);
                     qq = {qq[15:0], 1'b1};
                  end else begin
                     qq = {qq[15:0], 1'b0};
                  end
                  rr = w[17:0];
               end
            end
            rem_in[s][l] = rr;
            quo_in[s][l] = qq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NumStages; s++) begin
            t_ff[s]     <= t_in[s];
            first_ff[s] <= first_in[s];
            six_ff[s]   <= six_in[s];
         end
         for (int s = 1; s < NumStages; s++) begin
            for (int l = 0; l < NumLanes; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumStages; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s < NumStages; s++) vld_ff[s] <= vld_in[s];
      end
   end

   // A lane matches when its remainder fits in 16 bits; the seventh lane
   // exists only for small offsets.
   always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
         match[l] = (rem_ff[Last][l] < LowLimit) && ((l < NumLanes - 1) || six_ff[Last]);
      end
   end

   // Lowest pending lane is the one being emitted.
   always_comb begin
      lane_sel = mask_ff & (~mask_ff + lane_mask_type'(1));
      sel_low  = '0;
      for (int l = 0; l < NumLanes; l++) begin
         if (lane_sel[l]) sel_low = low_ff[l];
      end
      rsp_valid          = ser_vld_ff;
      rsp_found          = found_ff;
      rsp_recovered_seed = found_ff ? {half_ff, sfirst_ff, sel_low} : 32'h0;
      rsp_last           = !found_ff ||
                           (half_ff && ((mask_ff & (mask_ff - lane_mask_type'(1))) == '0));
   end

   always_comb begin
      ser_vld_in = ser_vld_ff;
      mask_in    = mask_ff;
      sfirst_in  = sfirst_ff;
      half_in    = half_ff;
      found_in   = found_ff;
      for (int l = 0; l < NumLanes; l++) low_in[l] = low_ff[l];
      if (ser_load) begin
         ser_vld_in = 1'b1;
         mask_in    = match;
         sfirst_in  = first_ff[Last];
         half_in    = 1'b0;
         found_in   = |match;
         for (int l = 0; l < NumLanes; l++) low_in[l] = quo_ff[Last][l][15:0];
      end else if (rsp_accept) begin
         if (rsp_last) begin
            ser_vld_in = 1'b0;
         end else if (half_ff) begin
            mask_in = mask_ff & ~lane_sel;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
      end else begin
         ser_vld_ff <= ser_vld_in;
      end
      mask_ff   <= mask_in;
      sfirst_ff <= sfirst_in;
      half_ff   <= half_in;
      found_ff  <= found_in;
      for (int l = 0; l < NumLanes; l++) low_ff[l] <= low_in[l];
   end

   // An empty answer is always a single, final beat.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_last)
      else $error("empty answer not marked last");

   // A pending solution always has a lane to emit.
   a_found_has_lane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> $onehot(lane_sel))
      else $error("found beat without a pending lane");

   // The final pipeline stage is never overwritten while it waits.
   a_hold_last_stage: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[Last] && !advance) |=> (vld_ff[Last] && $stable(t_ff[Last])))
      else $error("stalled stage changed");

   // The flipped copy of a solution follows only after its plain beat.
   a_half_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_found && !rsp_last && !half_ff) |=> (rsp_valid && half_ff))
      else $error("flipped copy missing");

endmodule

FILE: sim/tb_lcg_seed_recovery_15bit_halves.sv
// Testbench for the LCG seed recovery block: drives random and directed request
// beats, predicts every response beat and compares them in order.
// Depends on lsr15_pkg and the RTL top level.
`timescale 1ns / 100ps

// Expected response beat.
typedef struct packed {
   logic [31:0] seed;
   logic        found;
   logic        last;
} seed_beat_type;

class seed_scoreboard;
   seed_beat_type pending[$];
   int            mismatches;

   // Works out every candidate first state for one request beat.
   function void note_request(logic [4:0] hp, logic [4:0] atk, logic [4:0] def,
                              logic [4:0] spa, logic [4:0] spd, logic [4:0] spe);
      logic [31:0]   first_state;
      logic [31:0]   second_state;
      logic [31:0]   gap;
      logic [63:0]   offset;
      logic [63:0]   kmax;
      logic [31:0]   low_half;
      seed_beat_type beat;
      int            count;
      first_state  = {1'b0, def, atk, hp, 16'h0};
      second_state = {1'b0, spd, spa, spe, 16'h0};
      gap    = second_state - first_state * 32'h343FD - 32'h0025_9EC4;
      offset = {33'h0, gap[30:0]};
      kmax   = (64'h3_43FA_BC02 - offset) >> 31;
      count  = 0;
      for (int k = 0; k < 7 && k <= kmax; k++) begin
         if ((offset % 64'h343FD) < 64'h10000) begin
            low_half = 32'((offset / 64'h343FD) & 64'hFFFF);
            beat = '{first_state | low_half, 1'b1, 1'b0};
            pending.push_back(beat);
            beat.seed[31] = ~beat.seed[31];
            pending.push_back(beat);
            count += 2;
         end
         offset += 64'h8000_0000;
      end
      if (count == 0) begin
         pending.push_back('{32'h0, 1'b0, 1'b1});
      end else begin
         pending[$].last = 1'b1;
      end
   endfunction

   function void check_response(logic [31:0] seed, logic found, logic last);
      seed_beat_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected beat seed=%h found=%b last=%b", seed, found, last);
         return;
      end
      want = pending.pop_front();
      if (want.seed !== seed || want.found !== found || want.last !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", want.seed, want.found,
                     want.last, seed, found, last);
      end
   endfunction
endclass

module tb_lcg_seed_recovery_15bit_halves;
   import lsr15_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_health_iv = '0;
   logic [4:0]  req_attack_iv = '0;
   logic [4:0]  req_defense_iv = '0;
   logic [4:0]  req_special_attack_iv = '0;
   logic [4:0]  req_special_defense_iv = '0;
   logic [4:0]  req_speed_iv = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_recovered_seed;
   logic        rsp_found;
   logic        rsp_last;

   // Percent of cycles each side idles, and a long hold-off of the receiver.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   seed_scoreboard board = new();

   lcg_seed_recovery_15bit_halves uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, or a long counted hold-off when requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Every accepted beat on either channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_health_iv, req_attack_iv, req_defense_iv,
                            req_special_attack_iv, req_special_defense_iv, req_speed_iv);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_recovered_seed, rsp_found, rsp_last);
   end

   // Offers one request beat and waits at clock edges until req_stall is low. Valid stays high
   // from one beat into the next when no idle cycle falls between them.
   task automatic send_beat(logic [29:0] fields);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_health_iv, req_attack_iv, req_defense_iv,
       req_special_attack_iv, req_special_defense_iv, req_speed_iv} <= fields;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Random beat: either fully random, or a genuine pair of successive states
   // so that matches come often.
   function automatic logic [29:0] random_fields();
      logic [31:0] s0;
      logic [31:0] s1;
      if ($urandom_range(99) < 60) begin
         s0 = $urandom();
         s1 = s0 * 32'h343FD + 32'h269EC3;
         return {s0[20:16], s0[25:21], s0[30:26], s1[25:21], s1[30:26], s1[20:16]};
      end
      return 30'($urandom());
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, single set bits and known successive pairs.
      send_beat('0);
      send_beat('1);
      for (int b = 0; b < 30; b += 2) send_beat(30'(1) << b);
      send_beat(30'h2AAA_AAAA);
      send_beat(30'h1555_5555);
      for (int d = 0; d < 5; d++) begin
         logic [31:0] s0;
         logic [31:0] s1;
         s0 = 32'h1234_5678 * (d + 1);
         s1 = s0 * 32'h343FD + 32'h269EC3;
         send_beat({s0[20:16], s0[25:21], s0[30:26], s1[25:21], s1[30:26], s1[20:16]});
      end
      go_quiet();

      // Phases of idling, then the long receiver hold-off.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         for (int n = 0; n < 90; n++) send_beat(random_fields());
         // The sender pauses here until every expected beat has come.
         go_quiet();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 300;
      for (int n = 0; n < 40; n++) send_beat(random_fields());
      go_quiet();
      repeat (20) @(posedge clock);

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("lcg_seed_recovery_15bit_halves test passed");
      end else begin
         $display("lcg_seed_recovery_15bit_halves test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("lcg_seed_recovery_15bit_halves test failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lsr15_pkg.sv
rtl/lcg_seed_recovery_15bit_halves.sv
sim/tb_lcg_seed_recovery_15bit_halves.sv
